[rtl/afm_pkg.sv]
// ----------------------------------------------------------------------------
// afm_pkg
// Types and constants of the affine map solver: request and response
// payloads, datapath widths and pipeline depths.
// ----------------------------------------------------------------------------
package afm_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // difference, product, 2x2 determinant and offset determinant widths
   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = 2 * COORD_WIDTH + 2;
   localparam int GW  = 2 * COORD_WIDTH + 3;
   localparam int HW  = GW - COORD_WIDTH;
   localparam int LPW = 2 * COORD_WIDTH + 1;
   localparam int HPW = COORD_WIDTH + HW;
   localparam int G3W = 3 * COORD_WIDTH + 5;

   // numerator width and divider remainder width
   localparam int NW  = (GW + FRAC_BITS > G3W) ? GW + FRAC_BITS : G3W;
   localparam int RW  = (NW > GW + COORD_WIDTH) ? NW : GW + COORD_WIDTH;

   // stages ahead of the dividers, divider stages, total
   localparam int PRE_STG = 7;
   localparam int DSTG    = COORD_WIDTH + 2;
   localparam int NSTG    = PRE_STG + DSTG;

   localparam int NLANE = 6;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] src_first_x;
      logic signed [COORD_WIDTH-1:0] src_first_y;
      logic signed [COORD_WIDTH-1:0] src_second_x;
      logic signed [COORD_WIDTH-1:0] src_second_y;
      logic signed [COORD_WIDTH-1:0] src_third_x;
      logic signed [COORD_WIDTH-1:0] src_third_y;
      logic signed [COORD_WIDTH-1:0] dst_first_x;
      logic signed [COORD_WIDTH-1:0] dst_first_y;
      logic signed [COORD_WIDTH-1:0] dst_second_x;
      logic signed [COORD_WIDTH-1:0] dst_second_y;
      logic signed [COORD_WIDTH-1:0] dst_third_x;
      logic signed [COORD_WIDTH-1:0] dst_third_y;
   } afm_req_type;

   typedef struct packed {
      logic                          solved;
      logic signed [COORD_WIDTH-1:0] x_gain_x;
      logic signed [COORD_WIDTH-1:0] x_gain_y;
      logic signed [COORD_WIDTH-1:0] x_offset;
      logic signed [COORD_WIDTH-1:0] y_gain_x;
      logic signed [COORD_WIDTH-1:0] y_gain_y;
      logic signed [COORD_WIDTH-1:0] y_offset;
   } afm_rsp_type;

endpackage

[rtl/afm_div.sv]
// ----------------------------------------------------------------------------
// afm_div
// Pipelined restoring divider, one quotient bit per stage, with saturation
// of the signed quotient to the coordinate width.
// ----------------------------------------------------------------------------
module afm_div
   import afm_pkg::*;
(
   input  logic                          clock,
   input  logic [DSTG-1:0]               en,
   input  logic [NW-1:0]                 num_mag,
   input  logic [GW-1:0]                 den_mag,
   input  logic                          neg,
   output logic signed [COORD_WIDTH-1:0] quo
);

   localparam int W = COORD_WIDTH;

   logic [RW-1:0] rem_ff [W+1];
   logic [GW-1:0] den_ff [W+1];
   logic [W-1:0]  quo_ff [W+1];
   logic          neg_ff [W+1];
   logic          sat_ff [W+1];
   logic signed [W-1:0] quo_out_ff;
   logic signed [W-1:0] quo_in;

   // quotient would need more than W bits: saturate
   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= RW'(num_mag);
         den_ff[0] <= den_mag;
         quo_ff[0] <= '0;
         neg_ff[0] <= neg;
         sat_ff[0] <= RW'(num_mag) >= (RW'(den_mag) << W);
      end
   end

   for (genvar gi = 1; gi <= W; gi++) begin : g_step
      logic [RW-1:0] sub;
      logic          take;
      always_comb begin
         sub  = RW'(den_ff[gi-1]) << (W - gi);
         take = rem_ff[gi-1] >= sub;
      end
      always_ff @(posedge clock) begin
         if (en[gi]) begin
            rem_ff[gi] <= take ? rem_ff[gi-1] - sub : rem_ff[gi-1];
            quo_ff[gi] <= {quo_ff[gi-1][W-2:0], take};
            den_ff[gi] <= den_ff[gi-1];
            neg_ff[gi] <= neg_ff[gi-1];
            sat_ff[gi] <= sat_ff[gi-1];
         end
      end
   end

   always_comb begin
      if (!neg_ff[W]) begin
         if (sat_ff[W] || quo_ff[W][W-1])
            quo_in = {1'b0, {(W-1){1'b1}}};
         else
            quo_in = $signed(quo_ff[W]);
      end else begin
         if (sat_ff[W] || (quo_ff[W][W-1] && (quo_ff[W][W-2:0] != '0)))
            quo_in = {1'b1, {(W-1){1'b0}}};
         else
            quo_in = $signed(-quo_ff[W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[W+1]) begin
         quo_out_ff <= quo_in;
      end
   end

   assign quo = quo_out_ff;

endmodule

[rtl/affine_map_from_three_points.sv]
// pipeline: 7 setup stages, then one divider stage per quotient bit plus
//    check and output, between an accepted request and its response
// throughput: one request per cycle unless a stalled response fills the pipe;
//    each stage moves whenever its successor is empty or moving, so bubbles collapse under a stall
// reset clears only the stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// affine_map_from_three_points
// Solves the 2D affine map taking three source points onto three target
// points by Cramer's rule: saturated Q16.16 gains, offsets in coordinate units.
// ----------------------------------------------------------------------------
module affine_map_from_three_points
   import afm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  afm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output afm_rsp_type rsp_data
);

   localparam int W = COORD_WIDTH;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] en;

   // stage 0: differences
   logic signed [DW-1:0] u1_ff, u2_ff, v1_ff, v2_ff;
   logic signed [DW-1:0] p1_ff [2];
   logic signed [DW-1:0] p2_ff [2];
   logic signed [W-1:0]  a0_ff [3];
   logic signed [W-1:0]  b0_ff [3];
   logic signed [W-1:0]  t0_ff [3][2];
   logic signed [W-1:0]  tf [2];
   logic signed [W-1:0]  ts [2];
   logic signed [W-1:0]  tt [2];

   // stage 1: products
   logic signed [PW-1:0] muv_ff, mvu_ff;
   logic signed [PW-1:0] g1a_ff [2];
   logic signed [PW-1:0] g1b_ff [2];
   logic signed [PW-1:0] g2a_ff [2];
   logic signed [PW-1:0] g2b_ff [2];

   // stages 2..4: determinants and offset partial products
   logic signed [GW-1:0]  d0_ff [3];
   logic signed [GW-1:0]  g1_ff [3][2];
   logic signed [GW-1:0]  g2_ff [3][2];
   logic signed [LPW-1:0] tl_ff [2];
   logic signed [LPW-1:0] al_ff [2];
   logic signed [LPW-1:0] bl_ff [2];
   logic signed [HPW-1:0] th_ff [2];
   logic signed [HPW-1:0] ah_ff [2];
   logic signed [HPW-1:0] bh_ff [2];
   logic signed [G3W-1:0] tp_ff [2];
   logic signed [G3W-1:0] ap_ff [2];
   logic signed [G3W-1:0] bp_ff [2];

   // stage 5: numerators; stage 6: magnitudes
   logic signed [NW-1:0] num_ff [NLANE];
   logic signed [GW-1:0] den_ff;
   logic                 sing_ff;
   logic [NW-1:0]        mag_ff [NLANE];
   logic [GW-1:0]        dmag_ff;
   logic                 neg_ff [NLANE];
   logic [DSTG:0]        sol_ff;
   logic signed [W-1:0]  quo [NLANE];

   // a stage loads when it is empty or its successor moves
   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--)
         en[k] = !vld_ff[k] || en[k+1];
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0])
            vld_ff[0] <= req_valid;
         for (int k = 1; k < NSTG; k++)
            if (en[k])
               vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_comb begin
      tf[0] = req_data.dst_first_x;
      tf[1] = req_data.dst_first_y;
      ts[0] = req_data.dst_second_x;
      ts[1] = req_data.dst_second_y;
      tt[0] = req_data.dst_third_x;
      tt[1] = req_data.dst_third_y;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u1_ff <= DW'(req_data.src_second_x) - DW'(req_data.src_first_x);
         u2_ff <= DW'(req_data.src_third_x) - DW'(req_data.src_first_x);
         v1_ff <= DW'(req_data.src_second_y) - DW'(req_data.src_first_y);
         v2_ff <= DW'(req_data.src_third_y) - DW'(req_data.src_first_y);
         a0_ff[0] <= req_data.src_first_x;
         b0_ff[0] <= req_data.src_first_y;
         for (int ax = 0; ax < 2; ax++) begin
            p1_ff[ax]    <= DW'(ts[ax]) - DW'(tf[ax]);
            p2_ff[ax]    <= DW'(tt[ax]) - DW'(tf[ax]);
            t0_ff[0][ax] <= tf[ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         muv_ff   <= u1_ff * v2_ff;
         mvu_ff   <= u2_ff * v1_ff;
         a0_ff[1] <= a0_ff[0];
         b0_ff[1] <= b0_ff[0];
         for (int ax = 0; ax < 2; ax++) begin
            g1a_ff[ax]   <= p1_ff[ax] * v2_ff;
            g1b_ff[ax]   <= p2_ff[ax] * v1_ff;
            g2a_ff[ax]   <= u1_ff * p2_ff[ax];
            g2b_ff[ax]   <= u2_ff * p1_ff[ax];
            t0_ff[1][ax] <= t0_ff[0][ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         d0_ff[0] <= GW'(muv_ff) - GW'(mvu_ff);
         a0_ff[2] <= a0_ff[1];
         b0_ff[2] <= b0_ff[1];
         for (int ax = 0; ax < 2; ax++) begin
            g1_ff[0][ax] <= GW'(g1a_ff[ax]) - GW'(g1b_ff[ax]);
            g2_ff[0][ax] <= GW'(g2a_ff[ax]) - GW'(g2b_ff[ax]);
            t0_ff[2][ax] <= t0_ff[1][ax];
         end
      end
   end

   // offset determinant products split at bit W of the wide factor
   always_ff @(posedge clock) begin
      if (en[3]) begin
         d0_ff[1] <= d0_ff[0];
         for (int ax = 0; ax < 2; ax++) begin
            tl_ff[ax] <= t0_ff[2][ax] * $signed({1'b0, d0_ff[0][W-1:0]});
            th_ff[ax] <= t0_ff[2][ax] * $signed(d0_ff[0][GW-1:W]);
            al_ff[ax] <= a0_ff[2] * $signed({1'b0, g1_ff[0][ax][W-1:0]});
            ah_ff[ax] <= a0_ff[2] * $signed(g1_ff[0][ax][GW-1:W]);
            bl_ff[ax] <= b0_ff[2] * $signed({1'b0, g2_ff[0][ax][W-1:0]});
            bh_ff[ax] <= b0_ff[2] * $signed(g2_ff[0][ax][GW-1:W]);
            g1_ff[1][ax] <= g1_ff[0][ax];
            g2_ff[1][ax] <= g2_ff[0][ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         d0_ff[2] <= d0_ff[1];
         for (int ax = 0; ax < 2; ax++) begin
            tp_ff[ax] <= (G3W'(th_ff[ax]) <<< W) + G3W'(tl_ff[ax]);
            ap_ff[ax] <= (G3W'(ah_ff[ax]) <<< W) + G3W'(al_ff[ax]);
            bp_ff[ax] <= (G3W'(bh_ff[ax]) <<< W) + G3W'(bl_ff[ax]);
            g1_ff[2][ax] <= g1_ff[1][ax];
            g2_ff[2][ax] <= g2_ff[1][ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         den_ff  <= d0_ff[2];
         sing_ff <= d0_ff[2] == '0;
         for (int ax = 0; ax < 2; ax++) begin
            num_ff[3*ax]   <= NW'(g1_ff[2][ax]) <<< FRAC_BITS;
            num_ff[3*ax+1] <= NW'(g2_ff[2][ax]) <<< FRAC_BITS;
            num_ff[3*ax+2] <= NW'(tp_ff[ax] - ap_ff[ax] - bp_ff[ax]);
         end
      end
   end

   // singular source: divide zero by one so every coefficient reads zero
   always_ff @(posedge clock) begin
      if (en[6]) begin
         dmag_ff   <= sing_ff ? GW'(1) :
                      (den_ff[GW-1] ? $unsigned(-den_ff) : $unsigned(den_ff));
         for (int l = 0; l < NLANE; l++) begin
            mag_ff[l] <= sing_ff ? '0 :
                         (num_ff[l][NW-1] ? $unsigned(-num_ff[l]) : $unsigned(num_ff[l]));
            neg_ff[l] <= !sing_ff && (num_ff[l][NW-1] ^ den_ff[GW-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[PRE_STG-1])
         sol_ff[0] <= !sing_ff;
      for (int k = 1; k <= DSTG; k++)
         if (en[PRE_STG+k-1])
            sol_ff[k] <= sol_ff[k-1];
   end

   for (genvar gl = 0; gl < NLANE; gl++) begin : g_lane
      afm_div u_div (
         .clock   (clock),
         .en      (en[PRE_STG +: DSTG]),
         .num_mag (mag_ff[gl]),
         .den_mag (dmag_ff),
         .neg     (neg_ff[gl]),
         .quo     (quo[gl])
      );
   end

   always_comb begin
      rsp_data.solved   = sol_ff[DSTG];
      rsp_data.x_gain_x = quo[0];
      rsp_data.x_gain_y = quo[1];
      rsp_data.x_offset = quo[2];
      rsp_data.y_gain_x = quo[3];
      rsp_data.y_gain_y = quo[4];
      rsp_data.y_offset = quo[5];
   end

endmodule

[tb/affine_map_from_three_points_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_map_from_three_points_test
// Self-checking bench for the three-point affine solver: a directed table
// followed by random triangles. Each response is compared with an exact
// wide-integer solution or a hand-written map for typed table rows; random
// request bursts with idle gaps and random response stalls are applied.
// ----------------------------------------------------------------------------
module affine_map_from_three_points_test;
   import afm_pkg::*;

   localparam int CLK_HALF   = 4;
   localparam int RAND_ITEMS = 850;
   localparam int LATENCY    = 41;
   localparam int CYCLE_CAP  = 400000;

   localparam logic signed [31:0] ONE  = 32'sh0001_0000;
   localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      afm_req_type req;
      bit          typed;
      afm_rsp_type rsp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   afm_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   afm_rsp_type rsp_data;

   afm_rsp_type pending_maps[$];
   int          error_count;
   int          cycle_count;
   row_type     rows[$];

   affine_map_from_three_points dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // quotient truncated toward zero, then clipped to the coordinate range
   function automatic logic [31:0] clip_quotient(wide_type num, wide_type den);
      wide_type q;
      q = num / den;
      if (q > wide_type'(SMAX)) return SMAX;
      if (q < wide_type'(SMIN)) return SMIN;
      return q[31:0];
   endfunction

   function automatic afm_rsp_type solve_map(afm_req_type r);
      wide_type    a0, b0, u1, u2, v1, v2, d0, t0, p1, p2, g1, g2, g3;
      afm_rsp_type m;
      logic [31:0] tgt [6];
      a0 = wide_type'($signed(r.src_first_y)) * 0 + wide_type'($signed(r.src_first_x));
      b0 = wide_type'($signed(r.src_first_y));
      u1 = wide_type'($signed(r.src_second_x)) - a0;
      v1 = wide_type'($signed(r.src_second_y)) - b0;
      u2 = wide_type'($signed(r.src_third_x)) - a0;
      v2 = wide_type'($signed(r.src_third_y)) - b0;
      d0 = u1 * v2 - u2 * v1;
      m = '0;
      if (d0 == 0) return m;
      m.solved = 1'b1;
      tgt = '{r.dst_first_x, r.dst_second_x, r.dst_third_x,
              r.dst_first_y, r.dst_second_y, r.dst_third_y};
      for (int ax = 0; ax < 2; ax++) begin
         t0 = wide_type'($signed(tgt[3*ax]));
         p1 = wide_type'($signed(tgt[3*ax+1])) - t0;
         p2 = wide_type'($signed(tgt[3*ax+2])) - t0;
         g1 = p1 * v2 - p2 * v1;
         g2 = u1 * p2 - u2 * p1;
         g3 = t0 * d0 - a0 * g1 - b0 * g2;
         if (ax == 0) begin
            m.x_gain_x = clip_quotient(g1 <<< FRAC_BITS, d0);
            m.x_gain_y = clip_quotient(g2 <<< FRAC_BITS, d0);
            m.x_offset = clip_quotient(g3, d0);
         end else begin
            m.y_gain_x = clip_quotient(g1 <<< FRAC_BITS, d0);
            m.y_gain_y = clip_quotient(g2 <<< FRAC_BITS, d0);
            m.y_offset = clip_quotient(g3, d0);
         end
      end
      return m;
   endfunction

   function automatic afm_req_type make_tri(logic [31:0] s[6], logic [31:0] d[6]);
      afm_req_type r;
      r.src_first_x  = s[0]; r.src_first_y  = s[1];
      r.src_second_x = s[2]; r.src_second_y = s[3];
      r.src_third_x  = s[4]; r.src_third_y  = s[5];
      r.dst_first_x  = d[0]; r.dst_first_y  = d[1];
      r.dst_second_x = d[2]; r.dst_second_y = d[3];
      r.dst_third_x  = d[4]; r.dst_third_y  = d[5];
      return r;
   endfunction

   task automatic add_row(afm_req_type r, bit typed, afm_rsp_type m);
      row_type w;
      w.req   = r;
      w.typed = typed;
      w.rsp   = m;
      rows.push_back(w);
   endtask

   function automatic logic [31:0] rand_coord(int shape);
      case (shape)
         0:       return $urandom();
         1:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         2:       return 32'($signed($urandom_range(0, 16)) - 8) <<< FRAC_BITS;
         default: return $urandom_range(0, 1) ? SMAX - $urandom_range(0, 3)
                                              : SMIN + $urandom_range(0, 3);
      endcase
   endfunction

   function automatic afm_req_type random_tri();
      logic [31:0] s[6], d[6];
      int          shape, kind;
      shape = $urandom_range(0, 9);
      shape = (shape < 4) ? 0 : (shape < 7) ? 1 : (shape < 9) ? 2 : 3;
      foreach (s[i]) s[i] = rand_coord(shape);
      foreach (d[i]) d[i] = rand_coord($urandom_range(0, 3));
      kind = $urandom_range(0, 9);
      // occasional degenerate or tiny source triangles
      if (kind == 0) begin
         s[4] = s[0]; s[5] = s[1];
      end else if (kind == 1) begin
         s[2] = s[0] + (s[4] - s[0]) * 2;
         s[3] = s[1] + (s[5] - s[1]) * 2;
      end else if (kind == 2) begin
         s[2] = s[0] + $urandom_range(0, 3);
         s[3] = s[1];
         s[5] = s[1] + $urandom_range(0, 3);
         s[4] = s[0];
      end
      return make_tri(s, d);
   endfunction

   task automatic build_table();
      afm_rsp_type id_map, zero_map;
      logic [31:0] s[6], d[6];
      zero_map = '0;
      id_map   = '0;
      id_map.solved   = 1'b1;
      id_map.x_gain_x = ONE;
      id_map.y_gain_y = ONE;
      // identity on the unit triangle
      s = '{0, 0, ONE, 0, 0, ONE};
      add_row(make_tri(s, s), 1'b1, id_map);
      // all points coincide
      s = '{0, 0, 0, 0, 0, 0};
      d = '{SMAX, SMIN, 1, 2, 3, 4};
      add_row(make_tri(s, d), 1'b1, zero_map);
      // collinear source
      s = '{0, 0, ONE, ONE, 2*ONE, 2*ONE};
      add_row(make_tri(s, d), 1'b1, zero_map);
      s = '{SMAX, SMAX, SMAX, SMAX, SMIN, SMIN};
      add_row(make_tri(s, d), 1'b1, zero_map);
      // tiny source triangle, huge targets: gains clip both ways
      s = '{0, 0, 1, 0, 0, 1};
      d = '{0, 0, SMAX, SMIN, SMIN, SMAX};
      add_row(make_tri(s, d), 1'b0, zero_map);
      d = '{SMAX, SMIN, SMIN, SMAX, SMAX, SMIN};
      add_row(make_tri(s, d), 1'b0, zero_map);
      // extreme corners
      s = '{SMIN, SMIN, SMAX, SMIN, SMIN, SMAX};
      d = '{SMAX, SMAX, SMIN, SMAX, SMAX, SMIN};
      add_row(make_tri(s, d), 1'b0, zero_map);
      s = '{SMAX, SMIN, SMIN, SMAX, SMAX, SMAX};
      d = '{32'hffff_ffff, 0, 32'h5555_5555, 32'haaaa_aaaa, SMIN, SMAX};
      add_row(make_tri(s, d), 1'b0, zero_map);
      // offsets and truncation toward zero
      s = '{ONE, ONE, 3*ONE, ONE, ONE, 4*ONE};
      d = '{5, -7, 11, 3, -13, 9};
      add_row(make_tri(s, d), 1'b0, zero_map);
      s = '{-3, 5, 7, -2, 1, 9};
      d = '{-1, 1, 2, -2, 3, -3};
      add_row(make_tri(s, d), 1'b0, zero_map);
      s = '{0, 0, 3, 0, 0, 3};
      d = '{-1, 1, -2, 2, 4, -4};
      add_row(make_tri(s, d), 1'b0, zero_map);
      for (int i = 0; i < 8; i++) add_row(random_tri(), 1'b0, zero_map);
   endtask

   // receiver stalls in modes that change every so often
   int stall_mode;
   int mode_left;
   int stall_run;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 300);
      end
      mode_left = mode_left - 1;
      if (stall_run > 0) begin
         stall_run = stall_run - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= (cycle_count % 5 < 2);
            default: begin
               stall_run = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 12) : 0;
               rsp_stall <= (stall_run > 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      afm_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_maps.size() == 0) begin
            $error("response with no request outstanding");
            error_count = error_count + 1;
         end else begin
            want = pending_maps.pop_front();
            if (rsp_data.solved !== want.solved) begin
               $error("solved: expected %0d, got %0d", want.solved, rsp_data.solved);
               error_count = error_count + 1;
            end
            if (rsp_data.x_gain_x !== want.x_gain_x) begin
               $error("x_gain_x: expected %h, got %h", want.x_gain_x, rsp_data.x_gain_x);
               error_count = error_count + 1;
            end
            if (rsp_data.x_gain_y !== want.x_gain_y) begin
               $error("x_gain_y: expected %h, got %h", want.x_gain_y, rsp_data.x_gain_y);
               error_count = error_count + 1;
            end
            if (rsp_data.x_offset !== want.x_offset) begin
               $error("x_offset: expected %h, got %h", want.x_offset, rsp_data.x_offset);
               error_count = error_count + 1;
            end
            if (rsp_data.y_gain_x !== want.y_gain_x) begin
               $error("y_gain_x: expected %h, got %h", want.y_gain_x, rsp_data.y_gain_x);
               error_count = error_count + 1;
            end
            if (rsp_data.y_gain_y !== want.y_gain_y) begin
               $error("y_gain_y: expected %h, got %h", want.y_gain_y, rsp_data.y_gain_y);
               error_count = error_count + 1;
            end
            if (rsp_data.y_offset !== want.y_offset) begin
               $error("y_offset: expected %h, got %h", want.y_offset, rsp_data.y_offset);
               error_count = error_count + 1;
            end
         end
      end
   end

   // holds one request until accepted, then pushes its expected map
   task automatic send_request(afm_req_type r, afm_rsp_type m);
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      pending_maps.push_back(m);
      @(negedge clock);
   endtask

   initial begin
      int burst_left;
      int idle_cycles;
      afm_req_type r;
      error_count = 0;
      cycle_count = 0;
      stall_mode  = 0;
      mode_left   = 0;
      stall_run   = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      build_table();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      burst_left = 0;
      for (int i = 0; i < rows.size() + RAND_ITEMS; i++) begin
         if (burst_left == 0) begin
            burst_left  = $urandom_range(1, 40);
            idle_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (idle_cycles > 0) begin
               req_valid = 1'b0;
               req_data  = random_tri();
               repeat (idle_cycles) @(negedge clock);
            end
         end
         burst_left = burst_left - 1;
         if (i < rows.size()) begin
            r = rows[i].req;
            send_request(r, rows[i].typed ? rows[i].rsp : solve_map(r));
         end else begin
            r = random_tri();
            send_request(r, solve_map(r));
         end
      end
      req_valid = 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
rtl/afm_pkg.sv
rtl/afm_div.sv
rtl/affine_map_from_three_points.sv
tb/affine_map_from_three_points_test.sv
